### rtl/terminal_key_decoder_cursor_core_defines.svh
// ----------------------------------------------------------------------------
// terminal key decoder assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef TERMINAL_KEY_DECODER_CURSOR_CORE_DEFINES_SVH
`define TERMINAL_KEY_DECODER_CURSOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define TKD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define TKD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TKD_ASSERT(lbl, prop, msg)
`define TKD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/tkd_pkg.sv
// ----------------------------------------------------------------------------
// tkd_pkg
// shared widths, key codes and character constants of the key decoder
// ----------------------------------------------------------------------------
package tkd_pkg;

	localparam int DIM_BITS  = 10;
	localparam int KEY_BITS  = 9;
	localparam int BYTE_BITS = 8;
	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;

	// register word indexes
	localparam logic REG_SCREEN_COLS = 1'b0;
	localparam logic REG_SCREEN_ROWS = 1'b1;

	localparam logic [DIM_BITS-1:0] COLS_RESET = DIM_BITS'(80);
	localparam logic [DIM_BITS-1:0] ROWS_RESET = DIM_BITS'(24);

	localparam logic [BYTE_BITS-1:0] CH_ESC   = 8'h1b;
	localparam logic [BYTE_BITS-1:0] CH_CTRLQ = 8'h11;
	localparam logic [BYTE_BITS-1:0] CH_LBRK  = 8'h5b;
	localparam logic [BYTE_BITS-1:0] CH_O     = 8'h4f;
	localparam logic [BYTE_BITS-1:0] CH_TILDE = 8'h7e;
	localparam logic [BYTE_BITS-1:0] CH_0     = 8'h30;
	localparam logic [BYTE_BITS-1:0] CH_1     = 8'h31;
	localparam logic [BYTE_BITS-1:0] CH_4     = 8'h34;
	localparam logic [BYTE_BITS-1:0] CH_5     = 8'h35;
	localparam logic [BYTE_BITS-1:0] CH_6     = 8'h36;
	localparam logic [BYTE_BITS-1:0] CH_7     = 8'h37;
	localparam logic [BYTE_BITS-1:0] CH_8     = 8'h38;
	localparam logic [BYTE_BITS-1:0] CH_9     = 8'h39;
	localparam logic [BYTE_BITS-1:0] CH_A     = 8'h41;
	localparam logic [BYTE_BITS-1:0] CH_B     = 8'h42;
	localparam logic [BYTE_BITS-1:0] CH_C     = 8'h43;
	localparam logic [BYTE_BITS-1:0] CH_D     = 8'h44;
	localparam logic [BYTE_BITS-1:0] CH_F     = 8'h46;
	localparam logic [BYTE_BITS-1:0] CH_H     = 8'h48;

	localparam logic [KEY_BITS-1:0] KEY_ESC   = 9'h01b;
	localparam logic [KEY_BITS-1:0] KEY_CTRLQ = 9'h011;
	localparam logic [KEY_BITS-1:0] K_LEFT    = 9'd256;
	localparam logic [KEY_BITS-1:0] K_RIGHT   = 9'd257;
	localparam logic [KEY_BITS-1:0] K_UP      = 9'd258;
	localparam logic [KEY_BITS-1:0] K_DOWN    = 9'd259;
	localparam logic [KEY_BITS-1:0] K_HOME    = 9'd260;
	localparam logic [KEY_BITS-1:0] K_END     = 9'd261;
	localparam logic [KEY_BITS-1:0] K_PGUP    = 9'd262;
	localparam logic [KEY_BITS-1:0] K_PGDN    = 9'd263;

	// ESC a b, two-byte sequences
	function automatic logic [KEY_BITS-1:0] decode_pair(
		input logic [BYTE_BITS-1:0] a,
		input logic [BYTE_BITS-1:0] b
	);
		logic [KEY_BITS-1:0] k;
		k = KEY_ESC;
		if (a == CH_LBRK) begin
			case (b)
				CH_A:    k = K_UP;
				CH_B:    k = K_DOWN;
				CH_C:    k = K_RIGHT;
				CH_D:    k = K_LEFT;
				CH_H:    k = K_HOME;
				CH_F:    k = K_END;
				default: k = KEY_ESC;
			endcase
		end else if (a == CH_O) begin
			if (b == CH_H) begin
				k = K_HOME;
			end else if (b == CH_F) begin
				k = K_END;
			end
		end
		return k;
	endfunction

	// ESC [ digit ~
	function automatic logic [KEY_BITS-1:0] decode_tilde(input logic [BYTE_BITS-1:0] d);
		logic [KEY_BITS-1:0] k;
		case (d)
			CH_1, CH_7: k = K_HOME;
			CH_4, CH_8: k = K_END;
			CH_5:       k = K_PGUP;
			CH_6:       k = K_PGDN;
			default:    k = KEY_ESC;
		endcase
		return k;
	endfunction

endpackage

### rtl/tkd_ifs.sv
// ----------------------------------------------------------------------------
// tkd channel interfaces
// terminal input channel and decoded key channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface tkd_term_if
	import tkd_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic                 mode;
	logic [BYTE_BITS-1:0] in_byte;

	modport source (output valid, output mode, output in_byte, input ready);
	modport sink   (input valid, input mode, input in_byte, output ready);
endinterface

interface tkd_key_if
	import tkd_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [KEY_BITS-1:0] key_code;
	logic [DIM_BITS-1:0] cursor_col;
	logic [DIM_BITS-1:0] cursor_row;
	logic                quit;

	modport source (output valid, output key_code, output cursor_col, output cursor_row,
		output quit, input ready);
	modport sink   (input valid, input key_code, input cursor_col, input cursor_row,
		input quit, output ready);
endinterface

### rtl/terminal_key_decoder_cursor_core.sv
// an accepted input transaction is held in the input register, and any key it yields in the result register
// throughput: one input transaction per cycle, sustained while results are taken
// the input register advances whenever the result register is empty or drained
// reset clears the parse phase, cursor and valid flags, screen size to 80x24
// ----------------------------------------------------------------------------
// terminal_key_decoder_cursor_core
// vt100 key escape decoder with cursor clamped to the configured screen size
// ----------------------------------------------------------------------------
`include "terminal_key_decoder_cursor_core_defines.svh"

module terminal_key_decoder_cursor_core
	import tkd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	tkd_term_if.sink             term,
	tkd_key_if.source            key,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ESC,
		PH_ESC1,
		PH_DIGIT
	} phase_t;

	// configuration
	logic [DIM_BITS-1:0] screen_cols_q;
	logic [DIM_BITS-1:0] screen_rows_q;
	logic                cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_cols_q <= COLS_RESET;
			screen_rows_q <= ROWS_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_SCREEN_COLS: screen_cols_q <= pwdata[DIM_BITS-1:0];
				REG_SCREEN_ROWS: screen_rows_q <= pwdata[DIM_BITS-1:0];
				default:         screen_cols_q <= screen_cols_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SCREEN_COLS: prdata = DATA_BITS'(screen_cols_q);
			REG_SCREEN_ROWS: prdata = DATA_BITS'(screen_rows_q);
			default:         prdata = '0;
		endcase
	end

	// input register
	logic                 valid_s1;
	logic                 mode_s1;
	logic [BYTE_BITS-1:0] byte_s1;
	logic                 adv_s1;
	logic                 out_valid_q;

	assign adv_s1     = valid_s1 && (!out_valid_q || key.ready);
	assign term.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (term.ready) begin
			valid_s1 <= term.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (term.ready && term.valid) begin
			mode_s1 <= term.mode;
			byte_s1 <= term.in_byte;
		end
	end

	// parse and cursor state
	phase_t               phase_q;
	logic [BYTE_BITS-1:0] first_q;
	logic [BYTE_BITS-1:0] second_q;
	logic [DIM_BITS-1:0]  col_q;
	logic [DIM_BITS-1:0]  row_q;
	logic [KEY_BITS-1:0]  key_q;
	logic                 quit_q;

	phase_t               phase_d;
	logic [BYTE_BITS-1:0] first_d;
	logic [BYTE_BITS-1:0] second_d;
	logic                 emit;
	logic [KEY_BITS-1:0]  key_d;

	always_comb begin
		phase_d  = phase_q;
		first_d  = first_q;
		second_d = second_q;
		emit     = 1'b0;
		key_d    = KEY_ESC;
		unique case (phase_q)
			PH_IDLE: begin
				if (!mode_s1) begin
					if (byte_s1 == CH_ESC) begin
						phase_d = PH_ESC;
					end else begin
						emit  = 1'b1;
						key_d = KEY_BITS'(byte_s1);
					end
				end
			end
			PH_ESC: begin
				if (mode_s1) begin
					emit    = 1'b1;
					phase_d = PH_IDLE;
				end else begin
					first_d = byte_s1;
					phase_d = PH_ESC1;
				end
			end
			PH_ESC1: begin
				phase_d = PH_IDLE;
				if (mode_s1) begin
					emit = 1'b1;
				end else if (first_q == CH_LBRK && byte_s1 inside {[CH_0:CH_9]}) begin
					second_d = byte_s1;
					phase_d  = PH_DIGIT;
				end else begin
					emit  = 1'b1;
					key_d = decode_pair(first_q, byte_s1);
				end
			end
			PH_DIGIT: begin
				phase_d = PH_IDLE;
				emit    = 1'b1;
				if (!mode_s1 && byte_s1 == CH_TILDE) begin
					key_d = decode_tilde(second_q);
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// cursor update, a zero screen size acts as one
	logic [DIM_BITS-1:0] cols_eff;
	logic [DIM_BITS-1:0] rows_eff;
	logic [DIM_BITS:0]   col_inc;
	logic [DIM_BITS:0]   row_inc;
	logic [DIM_BITS-1:0] col_d;
	logic [DIM_BITS-1:0] row_d;

	assign cols_eff = (screen_cols_q == '0) ? DIM_BITS'(1) : screen_cols_q;
	assign rows_eff = (screen_rows_q == '0) ? DIM_BITS'(1) : screen_rows_q;
	assign col_inc  = {1'b0, col_q} + (DIM_BITS+1)'(1);
	assign row_inc  = {1'b0, row_q} + (DIM_BITS+1)'(1);

	always_comb begin
		col_d = col_q;
		row_d = row_q;
		case (key_d)
			K_LEFT:  if (col_q != '0) col_d = col_q - DIM_BITS'(1);
			K_RIGHT: if (col_inc < {1'b0, cols_eff}) col_d = col_inc[DIM_BITS-1:0];
			K_UP:    if (row_q != '0) row_d = row_q - DIM_BITS'(1);
			K_DOWN:  if (row_inc < {1'b0, rows_eff}) row_d = row_inc[DIM_BITS-1:0];
			K_PGUP:  row_d = '0;
			K_PGDN:  row_d = rows_eff - DIM_BITS'(1);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			first_q     <= '0;
			second_q    <= '0;
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (adv_s1 && emit) || (out_valid_q && !key.ready);
			if (adv_s1) begin
				phase_q  <= phase_d;
				first_q  <= first_d;
				second_q <= second_d;
				if (emit) begin
					col_q <= col_d;
					row_q <= row_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			key_q  <= key_d;
			quit_q <= (key_d == KEY_CTRLQ);
		end
	end

	assign key.valid      = out_valid_q;
	assign key.key_code   = key_q;
	assign key.cursor_col = col_q;
	assign key.cursor_row = row_q;
	assign key.quit       = quit_q;

	`TKD_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> phase_q == PH_IDLE && col_q == '0, "no reset")
	`TKD_ASSERT(a_accept_loads, term.valid && term.ready |=> valid_s1, "input transaction lost")
	`TKD_ASSERT(a_digit_ends, adv_s1 && phase_q == PH_DIGIT |=> phase_q == PH_IDLE && out_valid_q, "no key")
	`TKD_ASSERT(a_esc1_entry, phase_q == PH_ESC1 && $past(phase_q) != PH_ESC1 |-> $past(phase_q) == PH_ESC, "bad entry")

endmodule

### tb/sv/tb_terminal_key_decoder_cursor_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_terminal_key_decoder_cursor_core
// drives terminal bytes and read timeouts into the key decoder, predicts each
// decoded key with the clamped cursor, and compares every key transaction
// ----------------------------------------------------------------------------
module tb_terminal_key_decoder_cursor_core
	import tkd_pkg::*;
();

	localparam logic MODE_BYTE    = 1'b0;
	localparam logic MODE_TIMEOUT = 1'b1;
	localparam int   LONG_HOLD    = 300;
	localparam int   DRAIN_TAIL   = 4;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_ESC,
		SEQ_PREFIX,
		SEQ_DIGIT
	} seq_state_t;

	typedef struct packed {
		logic                 mode;
		logic [BYTE_BITS-1:0] data;
	} term_item_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key_code;
		logic [DIM_BITS-1:0] col;
		logic [DIM_BITS-1:0] row;
		logic                quit;
	} key_result_t;

	class key_tracker;
		logic [DIM_BITS-1:0]  cols;
		logic [DIM_BITS-1:0]  rows;
		logic [DIM_BITS-1:0]  col;
		logic [DIM_BITS-1:0]  row;
		logic [BYTE_BITS-1:0] prefix;
		logic [BYTE_BITS-1:0] digit;
		seq_state_t           state;
		key_result_t          expected_keys[$];
		int                   errors;

		function new();
			cols   = COLS_RESET;
			rows   = ROWS_RESET;
			col    = '0;
			row    = '0;
			prefix = '0;
			digit  = '0;
			state  = SEQ_IDLE;
			errors = 0;
		endfunction

		function void set_screen(logic idx, logic [DIM_BITS-1:0] v);
			if (idx == REG_SCREEN_COLS) begin
				cols = v;
			end else begin
				rows = v;
			end
		endfunction

		function int pending();
			return expected_keys.size();
		endfunction

		function logic [KEY_BITS-1:0] pair_key(logic [BYTE_BITS-1:0] a, logic [BYTE_BITS-1:0] b);
			if (a == CH_LBRK) begin
				case (b)
					CH_A: return K_UP;
					CH_B: return K_DOWN;
					CH_C: return K_RIGHT;
					CH_D: return K_LEFT;
					CH_H: return K_HOME;
					CH_F: return K_END;
					default: return KEY_ESC;
				endcase
			end
			if (a == CH_O && b == CH_H) begin
				return K_HOME;
			end
			if (a == CH_O && b == CH_F) begin
				return K_END;
			end
			return KEY_ESC;
		endfunction

		function logic [KEY_BITS-1:0] tilde_key(logic [BYTE_BITS-1:0] d);
			case (d)
				CH_1, CH_7: return K_HOME;
				CH_4, CH_8: return K_END;
				CH_5:       return K_PGUP;
				CH_6:       return K_PGDN;
				default:    return KEY_ESC;
			endcase
		endfunction

		// a zero screen size behaves as one
		function void move_cursor(logic [KEY_BITS-1:0] k);
			int lim_c;
			int lim_r;
			lim_c = (cols == 0) ? 1 : int'(cols);
			lim_r = (rows == 0) ? 1 : int'(rows);
			case (k)
				K_LEFT: begin
					if (col != 0) col = col - 1'b1;
				end
				K_RIGHT: begin
					if (int'(col) + 1 < lim_c) col = col + 1'b1;
				end
				K_UP: begin
					if (row != 0) row = row - 1'b1;
				end
				K_DOWN: begin
					if (int'(row) + 1 < lim_r) row = row + 1'b1;
				end
				K_PGUP: begin
					row = '0;
				end
				K_PGDN: begin
					row = DIM_BITS'(lim_r - 1);
				end
				default: begin
				end
			endcase
		endfunction

		function void take_input(logic m, logic [BYTE_BITS-1:0] d);
			logic [KEY_BITS-1:0] k;
			bit                  has_key;
			key_result_t         res;
			has_key = 1'b1;
			k = KEY_ESC;
			case (state)
				SEQ_IDLE: begin
					if (m == MODE_TIMEOUT) begin
						has_key = 1'b0;
					end else if (d == CH_ESC) begin
						state = SEQ_ESC;
						has_key = 1'b0;
					end else begin
						k = {1'b0, d};
					end
				end
				SEQ_ESC: begin
					if (m == MODE_TIMEOUT) begin
						state = SEQ_IDLE;
					end else begin
						prefix = d;
						state = SEQ_PREFIX;
						has_key = 1'b0;
					end
				end
				SEQ_PREFIX: begin
					state = SEQ_IDLE;
					if (m == MODE_BYTE) begin
						if (prefix == CH_LBRK && d >= CH_0 && d <= CH_9) begin
							digit = d;
							state = SEQ_DIGIT;
							has_key = 1'b0;
						end else begin
							k = pair_key(prefix, d);
						end
					end
				end
				default: begin
					state = SEQ_IDLE;
					if (m == MODE_BYTE && d == CH_TILDE) k = tilde_key(digit);
				end
			endcase
			if (has_key) begin
				move_cursor(k);
				res.key_code = k;
				res.col = col;
				res.row = row;
				res.quit = (k == KEY_CTRLQ);
				expected_keys.push_back(res);
			end
		endfunction

		function void check_key(key_result_t got);
			key_result_t want;
			if (expected_keys.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected key transaction: key %0d col %0d row %0d quit %0b",
						got.key_code, got.col, got.row, got.quit);
				end
				return;
			end
			want = expected_keys.pop_front();
			if (got.key_code !== want.key_code || got.col !== want.col ||
				got.row !== want.row || got.quit !== want.quit) begin
				errors++;
				if (errors <= 10) begin
					$display("key mismatch: expected key %0d col %0d row %0d quit %0b, got key %0d col %0d row %0d quit %0b",
						want.key_code, want.col, want.row, want.quit,
						got.key_code, got.col, got.row, got.quit);
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	tkd_term_if term_bus ();
	tkd_key_if  key_bus ();

	key_tracker tracker = new();
	term_item_t stim_seq[$];
	int         tx_idle_pct;
	int         rx_idle_pct;
	int         hold_reqs;
	int         hold_done;

	terminal_key_decoder_cursor_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.term    (term_bus),
		.key     (key_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls plus a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		key_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				key_bus.ready <= 1'b0;
			end else if (hold_reqs != hold_done) begin
				hold_done++;
				hold_left = LONG_HOLD - 1;
				key_bus.ready <= 1'b0;
			end else begin
				key_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && term_bus.valid && term_bus.ready) begin
			tracker.take_input(term_bus.mode, term_bus.in_byte);
		end
	end

	always @(posedge clk) begin : key_monitor
		key_result_t got;
		if (arst_n && key_bus.valid && key_bus.ready) begin
			got.key_code = key_bus.key_code;
			got.col = key_bus.cursor_col;
			got.row = key_bus.cursor_row;
			got.quit = key_bus.quit;
			tracker.check_key(got);
		end
	end

	task automatic send_item(input logic m, input logic [BYTE_BITS-1:0] d);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			term_bus.valid <= 1'b0;
			@(posedge clk);
		end
		term_bus.valid <= 1'b1;
		term_bus.mode <= m;
		term_bus.in_byte <= d;
		do @(posedge clk); while (!term_bus.ready);
	endtask

	// input side goes quiet until every key has come back
	task automatic wait_idle();
		term_bus.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [DIM_BITS-1:0] v);
		logic [DATA_BITS-1:0] w;
		w = $urandom();
		w[DIM_BITS-1:0] = v;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_BITS'({idx, 2'b00});
		pwdata <= w;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		tracker.set_screen(idx, v);
	endtask

	function void queue_term(logic m, logic [BYTE_BITS-1:0] d);
		term_item_t it;
		it.mode = m;
		it.data = d;
		stim_seq.push_back(it);
	endfunction

	// well-formed escape sequences, plain bytes, ctrl-q, lone timeouts and broken sequences
	task automatic send_random_sequence(output int counted);
		logic [BYTE_BITS-1:0] arrows[4];
		logic [BYTE_BITS-1:0] ends[2];
		logic [BYTE_BITS-1:0] listed[6];
		logic [BYTE_BITS-1:0] any_digit;
		int                   pick;
		arrows = '{CH_A, CH_B, CH_C, CH_D};
		ends = '{CH_H, CH_F};
		listed = '{CH_1, CH_4, CH_5, CH_6, CH_7, CH_8};
		any_digit = CH_0 + BYTE_BITS'($urandom_range(0, 9));
		stim_seq.delete();
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			queue_term(MODE_BYTE, CH_ESC);
			queue_term(MODE_BYTE, CH_LBRK);
			queue_term(MODE_BYTE, arrows[$urandom_range(0, 3)]);
		end else if (pick < 38) begin
			queue_term(MODE_BYTE, CH_ESC);
			queue_term(MODE_BYTE, $urandom_range(0, 1) ? CH_LBRK : CH_O);
			queue_term(MODE_BYTE, ends[$urandom_range(0, 1)]);
		end else if (pick < 48) begin
			queue_term(MODE_BYTE, CH_ESC);
			queue_term(MODE_BYTE, CH_LBRK);
			queue_term(MODE_BYTE, $urandom_range(0, 3) ? listed[$urandom_range(0, 5)] : any_digit);
			queue_term(MODE_BYTE, CH_TILDE);
		end else if (pick < 70) begin
			queue_term(MODE_BYTE, BYTE_BITS'($urandom_range(0, 255)));
		end else if (pick < 74) begin
			queue_term(MODE_BYTE, CH_CTRLQ);
		end else if (pick < 78) begin
			queue_term(MODE_TIMEOUT, BYTE_BITS'($urandom_range(0, 255)));
		end else if (pick < 82) begin
			queue_term(MODE_BYTE, CH_ESC);
			queue_term(MODE_TIMEOUT, BYTE_BITS'($urandom_range(0, 255)));
		end else if (pick < 86) begin
			queue_term(MODE_BYTE, CH_ESC);
			queue_term(MODE_BYTE, $urandom_range(0, 1) ? CH_LBRK : CH_O);
			queue_term(MODE_TIMEOUT, BYTE_BITS'($urandom_range(0, 255)));
		end else if (pick < 90) begin
			queue_term(MODE_BYTE, CH_ESC);
			queue_term(MODE_BYTE, CH_LBRK);
			queue_term(MODE_BYTE, any_digit);
			queue_term($urandom_range(0, 1) ? MODE_TIMEOUT : MODE_BYTE,
				BYTE_BITS'($urandom_range(0, 255)));
		end else if (pick < 96) begin
			queue_term(MODE_BYTE, CH_ESC);
			queue_term(MODE_BYTE, BYTE_BITS'($urandom_range(0, 255)));
			queue_term(MODE_BYTE, BYTE_BITS'($urandom_range(0, 255)));
		end else begin
			queue_term(MODE_BYTE, CH_ESC);
			queue_term(MODE_BYTE, CH_O);
			queue_term(MODE_BYTE, BYTE_BITS'($urandom_range(0, 255)));
		end
		// a timeout while idle is simply dropped by the block
		counted = (pick >= 74 && pick < 78) ? 0 : stim_seq.size();
		foreach (stim_seq[i]) send_item(stim_seq[i].mode, stim_seq[i].data);
	endtask

	task automatic run_random(input int n_items);
		int sent;
		int cnt;
		sent = 0;
		while (sent < n_items) begin
			send_random_sequence(cnt);
			sent += cnt;
		end
	endtask

	initial begin
		term_item_t          plan[$];
		logic [DIM_BITS-1:0] c;
		logic [DIM_BITS-1:0] r;
		arst_n <= 1'b0;
		term_bus.valid <= 1'b0;
		term_bus.mode <= MODE_BYTE;
		term_bus.in_byte <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		tx_idle_pct = 35;
		rx_idle_pct = 47;
		hold_reqs = 0;
		hold_done = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte extremes, quit, idle timeout, clamps at both edges, broken sequences
		plan = '{
			'{MODE_BYTE, 8'h00}, '{MODE_BYTE, 8'hff}, '{MODE_BYTE, CH_CTRLQ},
			'{MODE_TIMEOUT, 8'hff},
			'{MODE_BYTE, CH_ESC}, '{MODE_BYTE, CH_LBRK}, '{MODE_BYTE, CH_A},
			'{MODE_BYTE, CH_ESC}, '{MODE_BYTE, CH_LBRK}, '{MODE_BYTE, CH_C},
			'{MODE_BYTE, CH_ESC}, '{MODE_BYTE, CH_LBRK}, '{MODE_BYTE, CH_6},
			'{MODE_BYTE, CH_TILDE},
			'{MODE_BYTE, CH_ESC}, '{MODE_BYTE, CH_LBRK}, '{MODE_BYTE, CH_B},
			'{MODE_BYTE, CH_ESC}, '{MODE_TIMEOUT, 8'h00},
			'{MODE_BYTE, CH_ESC}, '{MODE_BYTE, CH_LBRK}, '{MODE_TIMEOUT, 8'h00},
			'{MODE_BYTE, CH_ESC}, '{MODE_BYTE, CH_LBRK}, '{MODE_BYTE, CH_9},
			'{MODE_BYTE, CH_TILDE}
		};
		foreach (plan[i]) send_item(plan[i].mode, plan[i].data);
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin c = 10'd5; r = 10'd4; end
				1: begin c = 10'd0; r = 10'd0; end
				2: begin c = 10'd1023; r = 10'd1023; end
				3: begin c = 10'd1; r = 10'd2; end
				4: begin
					c = DIM_BITS'($urandom_range(1, 16));
					r = DIM_BITS'($urandom_range(1, 16));
				end
				5: begin c = 10'd3; r = 10'd1023; end
				6: begin
					c = DIM_BITS'($urandom_range(0, 1023));
					r = DIM_BITS'($urandom_range(0, 1023));
				end
				default: begin c = 10'd7; r = 10'd7; end
			endcase
			if (p < 3) begin
				tx_idle_pct = 35;
				rx_idle_pct = 47;
			end else if (p < 6) begin
				tx_idle_pct = 47;
				rx_idle_pct = 35;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			write_reg(REG_SCREEN_COLS, c);
			write_reg(REG_SCREEN_ROWS, r);
			run_random(70);
			// back up the output while input keeps coming
			if (p == 1) hold_reqs++;
			if (p == 4) wait_idle();
			run_random(70);
			wait_idle();
		end

		if (tracker.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/tkd_pkg.sv
rtl/tkd_ifs.sv
rtl/terminal_key_decoder_cursor_core.sv
tb/sv/tb_terminal_key_decoder_cursor_core.sv
